>>> src/gdb_pkg.sv
`default_nettype none
package gdb_pkg;

	// Field widths
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned COUNT_W = 23;

	// Shared multiplier operand and product widths
	localparam int unsigned MUL_A_W = 14;
	localparam int unsigned MUL_B_W = 13;
	localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

	// floor(v / 25) = (v * RECIP25) >> RECIP_SHIFT, exact for v < 43690
	localparam logic [MUL_B_W-1:0] RECIP25       = 13'd5243;
	localparam int unsigned        RECIP_SHIFT   = 17;
	localparam logic [MUL_B_W-1:0] DAYS_PER_YEAR = 13'd365;

	// Largest positive day count
	localparam logic [COUNT_W-1:0] DAY_COUNT_MAX = 23'd4194303;

	// Quotient width of the divide-by-25 steps (at most 163)
	localparam int unsigned QUO_W = 8;

	// Sequencer states
	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_F100   = 6'b000010,
		ST_F400   = 6'b000100,
		ST_Y365   = 6'b001000,
		ST_ACCUM  = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	// Days before the first of a month; month 0 reads as January,
	// months 13..15 as December
	function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
		logic [8:0] r;
		unique case (m)
			4'd0, 4'd1: r = 9'd0;
			4'd2:       r = 9'd31;
			4'd3:       r = 9'd59;
			4'd4:       r = 9'd90;
			4'd5:       r = 9'd120;
			4'd6:       r = 9'd151;
			4'd7:       r = 9'd181;
			4'd8:       r = 9'd212;
			4'd9:       r = 9'd243;
			4'd10:      r = 9'd273;
			4'd11:      r = 9'd304;
			default:    r = 9'd334;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> src/gregorian_days_between_top.sv
// Channel  | Ports                                           | Handshake
// ---------+-------------------------------------------------+-------------------------
// request  | since_year/month/day, till_year/month/day       | taken when start && !busy
// result   | day_count (signed)                              | valid for one cycle on done
//
// A request runs through four steps per date: two divide-by-25 reciprocal products
// and the year times 365 on the one shared 14x13 multiplier, then accumulation;
// one final step saturates the result.
// busy is high from the accepting edge until done; no new request meanwhile.
// arst_n clears the sequencer and the done strobe.
// done cannot be stalled: the receiver takes day_count in that cycle.
`default_nettype none
module gregorian_days_between_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [gdb_pkg::YEAR_W-1:0]        since_year,
	input  wire logic [gdb_pkg::MONTH_W-1:0]       since_month,
	input  wire logic [gdb_pkg::DAY_W-1:0]         since_day,
	input  wire logic [gdb_pkg::YEAR_W-1:0]        till_year,
	input  wire logic [gdb_pkg::MONTH_W-1:0]       till_month,
	input  wire logic [gdb_pkg::DAY_W-1:0]         till_day,
	output logic                                   done,
	output logic signed [gdb_pkg::COUNT_W-1:0]     day_count
);

	localparam int unsigned ACC_W   = gdb_pkg::COUNT_W + 2;
	localparam int unsigned SMALL_W = 14;

	gdb_pkg::state_t state_q;
	logic                              sel_q;
	logic [gdb_pkg::YEAR_W-1:0]        since_year_q, till_year_q;
	logic [gdb_pkg::MONTH_W-1:0]       since_month_q, till_month_q;
	logic [gdb_pkg::DAY_W-1:0]         since_day_q, till_day_q;
	logic [gdb_pkg::MUL_P_W-1:0]       prod_q;
	logic [gdb_pkg::QUO_W-1:0]         f100_q;
	logic [SMALL_W-1:0]                small_q;
	logic signed [ACC_W-1:0]           acc_q;
	logic                              done_q;
	logic [gdb_pkg::COUNT_W-1:0]       day_count_q;

	// Current date operands
	logic [gdb_pkg::YEAR_W-1:0]  yr;
	logic [gdb_pkg::MONTH_W-1:0] mon;
	logic [gdb_pkg::DAY_W-1:0]   dy;

	assign yr  = sel_q ? till_year_q  : since_year_q;
	assign mon = sel_q ? till_month_q : since_month_q;
	assign dy  = sel_q ? till_day_q   : since_day_q;

	// Shared multiplier operand select
	logic [gdb_pkg::MUL_A_W-1:0] mul_a;
	logic [gdb_pkg::MUL_B_W-1:0] mul_b;

	always_comb begin
		unique case (state_q)
			gdb_pkg::ST_F100: begin
				mul_a = {2'b00, yr[13:2]};
				mul_b = gdb_pkg::RECIP25;
			end
			gdb_pkg::ST_F400: begin
				mul_a = {4'b0000, yr[13:4]};
				mul_b = gdb_pkg::RECIP25;
			end
			gdb_pkg::ST_Y365: begin
				mul_a = yr;
				mul_b = gdb_pkg::DAYS_PER_YEAR;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Leap terms, evaluated while floor(y/400) sits in the product register
	logic [gdb_pkg::QUO_W-1:0] f400;
	logic [12:0]               t25_100, t25_400;
	logic                      div4, div100, div400, leap, adj;
	logic [SMALL_W-1:0]        ceil4, ceil100, ceil400, small_d;

	assign f400    = prod_q[gdb_pkg::RECIP_SHIFT +: gdb_pkg::QUO_W];
	assign t25_100 = {1'b0, f100_q, 4'b0000} + {2'b00, f100_q, 3'b000} + {5'b0, f100_q};
	assign t25_400 = {1'b0, f400, 4'b0000} + {2'b00, f400, 3'b000} + {5'b0, f400};
	assign div4    = (yr[1:0] == 2'b00);
	assign div100  = div4 && ({1'b0, yr[13:2]} == t25_100);
	assign div400  = (yr[3:0] == 4'b0000) && ({3'b000, yr[13:4]} == t25_400);
	assign leap    = div4 && (!div100 || div400);
	assign adj     = leap && (mon >= 4'd3);
	assign ceil4   = {2'b00, yr[13:2]} + {13'd0, !div4};
	assign ceil100 = {6'd0, f100_q} + {13'd0, !div100};
	assign ceil400 = {6'd0, f400} + {13'd0, !div400};
	assign small_d = ceil4 - ceil100 + ceil400
		+ {5'd0, gdb_pkg::month_start(mon)} + {9'd0, dy} + {13'd0, adj};

	// Serial of the current date, added or subtracted by which date it is
	logic [ACC_W-1:0] serial;
	assign serial = {2'b00, prod_q[gdb_pkg::COUNT_W-1:0]} + {{(ACC_W-SMALL_W){1'b0}}, small_q};

	// Sequencer registers and done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gdb_pkg::ST_IDLE;
			sel_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				gdb_pkg::ST_IDLE: begin
					if (start) begin
						sel_q   <= 1'b0;
						state_q <= gdb_pkg::ST_F100;
					end
				end
				gdb_pkg::ST_F100:  state_q <= gdb_pkg::ST_F400;
				gdb_pkg::ST_F400:  state_q <= gdb_pkg::ST_Y365;
				gdb_pkg::ST_Y365:  state_q <= gdb_pkg::ST_ACCUM;
				gdb_pkg::ST_ACCUM: begin
					if (!sel_q) begin
						sel_q   <= 1'b1;
						state_q <= gdb_pkg::ST_F100;
					end else begin
						state_q <= gdb_pkg::ST_FINISH;
					end
				end
				gdb_pkg::ST_FINISH: begin
					done_q  <= 1'b1;
					state_q <= gdb_pkg::ST_IDLE;
				end
				default: state_q <= gdb_pkg::ST_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			gdb_pkg::ST_IDLE: begin
				if (start) begin
					since_year_q  <= since_year;
					since_month_q <= since_month;
					since_day_q   <= since_day;
					till_year_q   <= till_year;
					till_month_q  <= till_month;
					till_day_q    <= till_day;
					acc_q         <= '0;
				end
			end
			gdb_pkg::ST_F400:  f100_q  <= prod_q[gdb_pkg::RECIP_SHIFT +: gdb_pkg::QUO_W];
			gdb_pkg::ST_Y365:  small_q <= small_d;
			gdb_pkg::ST_ACCUM: begin
				if (sel_q) acc_q <= acc_q + $signed(serial);
				else       acc_q <= acc_q - $signed(serial);
			end
			gdb_pkg::ST_FINISH: begin
				priority if (acc_q < 0)
					day_count_q <= '1;
				else if (acc_q > $signed({2'b00, gdb_pkg::DAY_COUNT_MAX}))
					day_count_q <= gdb_pkg::DAY_COUNT_MAX;
				else
					day_count_q <= acc_q[gdb_pkg::COUNT_W-1:0];
			end
			default: ;
		endcase
	end

	assign busy      = (state_q != gdb_pkg::ST_IDLE);
	assign done      = done_q;
	assign day_count = day_count_q;

endmodule
`default_nettype wire

>>> tb/testbench.sv
`default_nettype none
module testbench;

	localparam int unsigned REQUEST_COUNT = 1050;
	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned DRAIN_CYCLES  = 30;

	// Days before the first of each month in a common year
	localparam int unsigned DAYS_BEFORE_MONTH [12] = '{
		0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
	};

	// One date pair plus the sender idle percentage used while presenting it
	typedef struct {
		logic [gdb_pkg::YEAR_W-1:0]  since_year;
		logic [gdb_pkg::MONTH_W-1:0] since_month;
		logic [gdb_pkg::DAY_W-1:0]   since_day;
		logic [gdb_pkg::YEAR_W-1:0]  till_year;
		logic [gdb_pkg::MONTH_W-1:0] till_month;
		logic [gdb_pkg::DAY_W-1:0]   till_day;
		int unsigned                 idle_pct;
	} date_req_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                start = 1'b0;
	logic                                busy;
	logic [gdb_pkg::YEAR_W-1:0]          since_year = '0;
	logic [gdb_pkg::MONTH_W-1:0]         since_month = '0;
	logic [gdb_pkg::DAY_W-1:0]           since_day = '0;
	logic [gdb_pkg::YEAR_W-1:0]          till_year = '0;
	logic [gdb_pkg::MONTH_W-1:0]         till_month = '0;
	logic [gdb_pkg::DAY_W-1:0]           till_day = '0;
	logic                                done;
	logic signed [gdb_pkg::COUNT_W-1:0]  day_count;

	date_req_t                           pending_dates [$];
	logic signed [gdb_pkg::COUNT_W-1:0]  expected_counts [$];
	logic                                req_taken = 1'b0;
	int unsigned                         error_count = 0;
	int unsigned                         cycle_count = 0;

	gregorian_days_between_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.since_year  (since_year),
		.since_month (since_month),
		.since_day   (since_day),
		.till_year   (till_year),
		.till_month  (till_month),
		.till_day    (till_day),
		.done        (done),
		.day_count   (day_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Day number of a date counted from year 0; out-of-range months clamp
	function automatic int unsigned date_serial(input logic [gdb_pkg::YEAR_W-1:0] y,
			input logic [gdb_pkg::MONTH_W-1:0] m, input logic [gdb_pkg::DAY_W-1:0] d);
		int unsigned yr;
		int unsigned mon;
		int unsigned s;
		bit          leap;
		yr   = y;
		mon  = (m == 0) ? 1 : ((m > 12) ? 12 : m);
		leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
		s = 365 * yr + (yr + 3) / 4 - (yr + 99) / 100 + (yr + 399) / 400
			+ DAYS_BEFORE_MONTH[mon-1] + d;
		if (mon > 2 && leap) begin
			s = s + 1;
		end
		return s;
	endfunction

	// Days from start date to end date, -1 when reversed, saturated on top
	function automatic logic signed [gdb_pkg::COUNT_W-1:0] predict_day_count(
			input date_req_t r);
		int unsigned a;
		int unsigned b;
		int unsigned diff;
		a = date_serial(r.since_year, r.since_month, r.since_day);
		b = date_serial(r.till_year, r.till_month, r.till_day);
		if (b < a) begin
			return '1;
		end
		diff = b - a;
		if (diff > gdb_pkg::DAY_COUNT_MAX) begin
			return gdb_pkg::DAY_COUNT_MAX;
		end
		return diff[gdb_pkg::COUNT_W-1:0];
	endfunction

	task automatic add_dates(input int unsigned sy, input int unsigned sm,
			input int unsigned sd, input int unsigned ty, input int unsigned tm,
			input int unsigned td, input int unsigned pct);
		date_req_t r;
		r.since_year  = sy[gdb_pkg::YEAR_W-1:0];
		r.since_month = sm[gdb_pkg::MONTH_W-1:0];
		r.since_day   = sd[gdb_pkg::DAY_W-1:0];
		r.till_year   = ty[gdb_pkg::YEAR_W-1:0];
		r.till_month  = tm[gdb_pkg::MONTH_W-1:0];
		r.till_day    = td[gdb_pkg::DAY_W-1:0];
		r.idle_pct    = pct;
		pending_dates.push_back(r);
	endtask

	// Years around the leap-rule boundaries and field extremes
	function automatic int unsigned edge_year();
		int unsigned picks [10];
		picks = '{0, 1, 99, 100, 399, 400, 1900, 2000, 9999, 16383};
		return picks[$urandom_range(0, 9)] + $urandom_range(0, 1);
	endfunction

	// Random request: mostly well-formed dates, some near or equal pairs,
	// some boundary years with odd months/days, and some raw bit patterns
	task automatic add_random_dates(input int unsigned pct);
		int unsigned kind;
		int unsigned sy;
		int unsigned sm;
		int unsigned sd;
		int unsigned ty;
		int unsigned tm;
		int unsigned td;
		kind = $urandom_range(0, 99);
		sy = $urandom_range(1, 9999);
		sm = $urandom_range(1, 12);
		sd = $urandom_range(1, 31);
		ty = $urandom_range(1, 9999);
		tm = $urandom_range(1, 12);
		td = $urandom_range(1, 31);
		if (kind < 55) begin
			add_dates(sy, sm, sd, ty, tm, td, pct);
		end else if (kind < 70) begin
			// nearby pair, either order
			ty = (sy < 9999) ? sy + $urandom_range(0, 1) : sy;
			if ($urandom_range(0, 1) == 1) begin
				add_dates(sy, sm, sd, ty, tm, td, pct);
			end else begin
				add_dates(ty, tm, td, sy, sm, sd, pct);
			end
		end else if (kind < 75) begin
			add_dates(sy, sm, sd, sy, sm, sd, pct);
		end else if (kind < 85) begin
			add_dates(edge_year(), $urandom_range(0, 15), $urandom_range(0, 31),
				edge_year(), $urandom_range(0, 15), $urandom_range(0, 31), pct);
		end else begin
			add_dates($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, pct);
		end
	endtask

	// Stimulus and end of run
	initial begin
		int unsigned phase_pct [4];
		phase_pct = '{0, 79, 0, 35};

		// extremes, leap rules, ordering and the out-of-range cases
		add_dates(1, 1, 1, 9999, 12, 31, 0);
		add_dates(2000, 2, 29, 2000, 3, 1, 0);
		add_dates(1900, 2, 28, 1900, 3, 1, 0);
		add_dates(2100, 2, 28, 2100, 3, 1, 0);
		add_dates(1600, 12, 31, 1601, 1, 1, 0);
		add_dates(2024, 5, 5, 2024, 5, 5, 0);
		add_dates(2024, 5, 6, 2024, 5, 5, 0);
		add_dates(9999, 12, 31, 1, 1, 1, 0);
		add_dates(0, 0, 0, 16383, 15, 31, 0);
		add_dates(16383, 15, 31, 16383, 15, 31, 0);
		add_dates(0, 0, 0, 0, 0, 0, 0);
		add_dates(2023, 0, 15, 2023, 1, 15, 0);
		add_dates(2023, 13, 1, 2023, 12, 1, 0);
		add_dates(2023, 15, 31, 2024, 12, 0, 0);
		add_dates(2021, 2, 31, 2021, 3, 3, 0);
		add_dates(2021, 3, 0, 2021, 2, 28, 0);
		add_dates(0, 3, 1, 0, 2, 29, 0);
		add_dates(0, 1, 1, 11491, 1, 1, 0);
		add_dates(10922, 6, 15, 16383, 1, 1, 0);
		add_dates(8191, 8, 16, 8192, 8, 16, 0);

		for (int unsigned i = 0; i < REQUEST_COUNT; i++) begin
			add_random_dates(phase_pct[(i / 150) % 4]);
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_dates.size() != 0 || start || expected_counts.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0 && expected_counts.size() == 0) begin
			$display("gregorian_days_between_top: match");
		end else begin
			$display("gregorian_days_between_top: mismatch");
		end
		$finish;
	end

	// Request driver: hold until taken, then present the next or idle
	always @(negedge clk) begin : drive_requests
		date_req_t r;
		if (arst_n && !(start && !req_taken)) begin
			if (pending_dates.size() != 0
					&& $urandom_range(1, 100) > pending_dates[0].idle_pct) begin
				r = pending_dates.pop_front();
				since_year  <= r.since_year;
				since_month <= r.since_month;
				since_day   <= r.since_day;
				till_year   <= r.till_year;
				till_month  <= r.till_month;
				till_day    <= r.till_day;
				start       <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: predict on acceptance, check each done strobe, watch the limit
	always @(posedge clk) begin : watch_results
		date_req_t r;
		logic signed [gdb_pkg::COUNT_W-1:0] want;
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("gregorian_days_between_top: mismatch");
			$finish;
		end
		req_taken <= start && !busy;
		if (arst_n && start && !busy) begin
			r.since_year  = since_year;
			r.since_month = since_month;
			r.since_day   = since_day;
			r.till_year   = till_year;
			r.till_month  = till_month;
			r.till_day    = till_day;
			r.idle_pct    = 0;
			expected_counts.push_back(predict_day_count(r));
		end
		if (arst_n && done) begin
			if (expected_counts.size() == 0) begin
				$display("%0t: unexpected result, actual day_count %0d", $time, day_count);
				error_count <= error_count + 1;
			end else begin
				want = expected_counts.pop_front();
				if (day_count !== want) begin
					$display("%0t: day_count expected %0d actual %0d",
						$time, want, day_count);
					error_count <= error_count + 1;
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> files.f
src/gdb_pkg.sv
src/gregorian_days_between_top.sv
tb/testbench.sv
